// File: hdl/scan_seg_pkg.sv
// Shared widths, constants and the object job type for the scan object segmenter.
package scan_seg_pkg;

  localparam int ANGLE_W  = 8;
  localparam int IR_W     = 12;
  localparam int DIST_W   = 16;
  localparam int IDX_W    = 3;
  localparam int CENTER_W = 9;
  localparam int CNT_W    = 4;
  localparam int QCNT_W   = 2;
  localparam int DIAM_W   = 16;

  localparam int PI_Q16_W    = 11;
  localparam int PROD1_W     = DIST_W + ANGLE_W;
  localparam int PROD2_W     = PROD1_W + PI_Q16_W;
  localparam int FRAC_W      = 16;

  localparam logic [PI_Q16_W-1:0] PI_OVER_180_Q16 = 11'd1144;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  localparam int DEF_MAX_OBJECTS     = 5;
  localparam int DEF_QUALIFY_SAMPLES = 3;
  localparam int QUEUE_DEPTH         = 2;

  typedef struct packed {
    logic [IDX_W-1:0]   index;
    logic [ANGLE_W-1:0] ang_first;
    logic [ANGLE_W-1:0] ang_last;
    logic [DIST_W-1:0]  obj_range;
  } job_t;

endpackage

// File: hdl/scan_object_segmenter.sv
// Top level of the scan object segmenter: stream ports, front end, job queue, back end.
// A closing sample's result goes through the queue, job, product and output registers.
// Throughput: the front end takes one sample per cycle while the job queue has room;
// the back end works on one object at a time in its two-multiply diameter chain.
// Every sample waits while the job queue is full.
// Reset (rst_n low, synchronous): threshold to 0, all run and object state cleared.
module scan_object_segmenter #(
  parameter int MAX_OBJECTS     = scan_seg_pkg::DEF_MAX_OBJECTS,
  parameter int QUALIFY_SAMPLES = scan_seg_pkg::DEF_QUALIFY_SAMPLES
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [scan_seg_pkg::IR_W-1:0]        cfg_wr_data,   // ir_threshold
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // angle_deg[7:0], ir_level[19:8], sonar_dist[35:20], zero pad
  input  logic [scan_seg_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                                 in_tuser,      // scan_start
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // object_index[2:0], center_half_deg[11:3], object_dist[27:12], object_diameter[43:28]
  output logic [scan_seg_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import scan_seg_pkg::*;

  logic                job_push;
  logic                job_pop;
  logic                job_full;
  logic                job_empty;
  job_t                job_wr;
  job_t                job_rd;
  logic [IDX_W-1:0]    res_index;
  logic [CENTER_W-1:0] res_center;
  logic [DIST_W-1:0]   res_dist;
  logic [DIAM_W-1:0]   res_diam;

  scan_seg_front #(
    .MAX_OBJECTS     (MAX_OBJECTS),
    .QUALIFY_SAMPLES (QUALIFY_SAMPLES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .smp_valid      (in_tvalid),
    .smp_ready      (in_tready),
    .smp_scan_start (in_tuser),
    .smp_angle      (in_tdata[7:0]),
    .smp_ir         (in_tdata[19:8]),
    .smp_dist       (in_tdata[35:20]),
    .job_push       (job_push),
    .job_data       (job_wr),
    .job_full       (job_full)
  );

  scan_seg_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (job_push),
    .wr_data (job_wr),
    .full    (job_full),
    .pop     (job_pop),
    .rd_data (job_rd),
    .empty   (job_empty)
  );

  scan_seg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_empty  (job_empty),
    .job_data   (job_rd),
    .job_pop    (job_pop),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_index  (res_index),
    .res_center (res_center),
    .res_dist   (res_dist),
    .res_diam   (res_diam)
  );

  assign out_tdata = {4'b0, res_diam, res_dist, res_center, res_index};

endmodule

// File: hdl/scan_seg_fifo.sv
// Small register queue between the sample front end and the object back end.
module scan_seg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue pop while empty");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("queue count out of range");

endmodule

// File: hdl/scan_seg_front.sv
// Sample front end: threshold, run qualification, object tracking and job issue.
module scan_seg_front #(
  parameter int MAX_OBJECTS     = scan_seg_pkg::DEF_MAX_OBJECTS,
  parameter int QUALIFY_SAMPLES = scan_seg_pkg::DEF_QUALIFY_SAMPLES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [scan_seg_pkg::IR_W-1:0]    cfg_wr_data,
  input  logic                             smp_valid,
  output logic                             smp_ready,
  input  logic                             smp_scan_start,
  input  logic [scan_seg_pkg::ANGLE_W-1:0] smp_angle,
  input  logic [scan_seg_pkg::IR_W-1:0]    smp_ir,
  input  logic [scan_seg_pkg::DIST_W-1:0]  smp_dist,
  output logic                             job_push,
  output scan_seg_pkg::job_t               job_data,
  input  logic                             job_full
);
  import scan_seg_pkg::*;

  localparam logic [QCNT_W-1:0] QUAL_LIM = QCNT_W'(QUALIFY_SAMPLES);
  localparam logic [CNT_W-1:0]  MAX_LIM  = CNT_W'(MAX_OBJECTS);

  logic [IR_W-1:0]    thr_r;
  logic [QCNT_W-1:0]  qcnt_r, qcnt_nxt;
  logic               in_obj_r, in_obj_nxt;
  logic [ANGLE_W-1:0] start_r, start_nxt;
  logic [ANGLE_W-1:0] end_r, end_nxt;
  logic [DIST_W-1:0]  dist_r, dist_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               accept;

  assign smp_ready = !job_full;
  assign accept    = smp_valid && smp_ready;

  always_comb begin
    qcnt_nxt   = qcnt_r;
    in_obj_nxt = in_obj_r;
    start_nxt  = start_r;
    end_nxt    = end_r;
    dist_nxt   = dist_r;
    cnt_nxt    = cnt_r;
    job_push   = 1'b0;
    if (accept) begin
      if (smp_scan_start) begin
        qcnt_nxt   = '0;
        in_obj_nxt = 1'b0;
        start_nxt  = '0;
        end_nxt    = '0;
        dist_nxt   = '0;
        cnt_nxt    = '0;
      end
      if (smp_ir > thr_r) begin
        if (qcnt_nxt < QUAL_LIM) begin
          qcnt_nxt = qcnt_nxt + 1'b1;
        end else begin
          if (!in_obj_nxt) begin
            in_obj_nxt = 1'b1;
            start_nxt  = smp_angle;
            dist_nxt   = smp_dist;
          end
          end_nxt = smp_angle;
        end
      end else begin
        qcnt_nxt = '0;
        if (in_obj_nxt) begin
          in_obj_nxt = 1'b0;
          if (cnt_nxt < MAX_LIM) begin
            job_push = 1'b1;
            cnt_nxt  = cnt_nxt + 1'b1;
          end
        end
      end
    end
  end

  // job fields come from the state as it stands when the run closes
  always_comb begin
    job_data.index     = cnt_nxt[IDX_W-1:0] - 1'b1;
    job_data.ang_first = start_nxt;
    job_data.ang_last  = end_nxt;
    job_data.obj_range = dist_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= '0;
      qcnt_r   <= '0;
      in_obj_r <= 1'b0;
      start_r  <= '0;
      end_r    <= '0;
      dist_r   <= '0;
      cnt_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      qcnt_r   <= qcnt_nxt;
      in_obj_r <= in_obj_nxt;
      start_r  <= start_nxt;
      end_r    <= end_nxt;
      dist_r   <= dist_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_LIM)
    else $error("object count above limit");

  a_qcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= QUAL_LIM)
    else $error("qualify count above limit");

  a_push_closes: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |=> (!in_obj_r && cnt_r == $past(cnt_nxt)))
    else $error("job issued without closing the object");

endmodule

// File: hdl/scan_seg_back.sv
// Object back end: centre, diameter multiply chain with rounding and saturation, output register.
module scan_seg_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 job_empty,
  input  scan_seg_pkg::job_t                   job_data,
  output logic                                 job_pop,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output logic [scan_seg_pkg::IDX_W-1:0]       res_index,
  output logic [scan_seg_pkg::CENTER_W-1:0]    res_center,
  output logic [scan_seg_pkg::DIST_W-1:0]      res_dist,
  output logic [scan_seg_pkg::DIAM_W-1:0]      res_diam
);
  import scan_seg_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL1 = 2'd1;
  localparam logic [1:0] ST_MUL2 = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  localparam logic [PROD2_W:0] ROUND_HALF = (PROD2_W + 1)'(1) << (FRAC_W - 1);
  localparam int               Q_W        = PROD2_W + 1 - FRAC_W;

  logic [1:0]          state_r, state_nxt;
  job_t                job_r;
  logic [ANGLE_W-1:0]  span_r;
  logic [PROD1_W-1:0]  p1_r;
  logic [PROD2_W-1:0]  p2_r;
  logic                out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]    out_index_r;
  logic [CENTER_W-1:0] out_center_r;
  logic [DIST_W-1:0]   out_dist_r;
  logic [DIAM_W-1:0]   out_diam_r;
  logic [ANGLE_W-1:0]  span_in;
  logic [PROD2_W:0]    rounded;
  logic [Q_W-1:0]      quot;
  logic [DIAM_W-1:0]   diam;
  logic                load_out;

  assign span_in = (job_data.ang_last >= job_data.ang_first) ?
                   (job_data.ang_last - job_data.ang_first) : '0;
  assign rounded = {1'b0, p2_r} + ROUND_HALF;
  assign quot    = rounded[PROD2_W:FRAC_W];
  assign diam    = (quot > Q_W'({DIAM_W{1'b1}})) ? {DIAM_W{1'b1}} : quot[DIAM_W-1:0];

  assign job_pop  = (state_r == ST_IDLE) && !job_empty;
  assign load_out = (state_r == ST_FIN) && (!out_valid_r || res_ready);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (!job_empty) begin
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_FIN;
      ST_FIN: begin
        if (load_out) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_r  <= job_data;
      span_r <= span_in;
    end
    if (state_r == ST_MUL1) begin
      p1_r <= PROD1_W'(job_r.obj_range) * PROD1_W'(span_r);
    end
    if (state_r == ST_MUL2) begin
      p2_r <= PROD2_W'(p1_r) * PROD2_W'(PI_OVER_180_Q16);
    end
    if (load_out) begin
      out_index_r  <= job_r.index;
      out_center_r <= CENTER_W'(job_r.ang_first) + CENTER_W'(job_r.ang_last);
      out_dist_r   <= job_r.obj_range;
      out_diam_r   <= diam;
    end
  end

  assign res_valid  = out_valid_r;
  assign res_index  = out_index_r;
  assign res_center = out_center_r;
  assign res_dist   = out_dist_r;
  assign res_diam   = out_diam_r;

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> (state_r == ST_MUL1))
    else $error("pop did not start the multiply chain");

  a_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL1) |=> (state_r == ST_MUL2) ##1 (state_r == ST_FIN))
    else $error("multiply chain out of sequence");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r)
    else $error("result load lost");

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the scan object segmenter: stream stimulus, object predictor, scoreboard.
module tb_top;
  import scan_seg_pkg::*;

  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_OBJ      = DEF_MAX_OBJECTS;
  localparam int QUAL_SAMPLES = DEF_QUALIFY_SAMPLES;
  localparam int N_DIR        = 26;
  localparam int N_PHASES     = 6;

  typedef struct packed {
    logic [IDX_W-1:0]    index;
    logic [CENTER_W-1:0] center;
    logic [DIST_W-1:0]   obj_range;
    logic [DIAM_W-1:0]   diam;
  } obj_t;

  typedef struct {
    bit st;
    int angle;
    int ir;
    int sonar;
    bit typed;
    int index;
    int center;
    int obj_range;
    int diam;
  } dir_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [IR_W-1:0]        cfg_wr_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // predictor state
  logic [IR_W-1:0]    seg_thr;
  logic [QCNT_W-1:0]  seg_qual;
  bit                 seg_open;
  logic [ANGLE_W-1:0] seg_start_ang;
  logic [ANGLE_W-1:0] seg_end_ang;
  logic [DIST_W-1:0]  seg_dist;
  logic [CNT_W-1:0]   seg_count;

  obj_t pending_objects[$];
  int   mismatch_count;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   sweep_angle;

  scan_object_segmenter u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    obj_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_objects.size() == 0) begin
        report_mismatch($sformatf("unexpected object tdata=%h", out_tdata));
      end else begin
        want = pending_objects.pop_front();
        if (out_tdata[2:0] !== want.index)
          report_mismatch($sformatf("index got %0d want %0d", out_tdata[2:0], want.index));
        if (out_tdata[11:3] !== want.center)
          report_mismatch($sformatf("center got %0d want %0d", out_tdata[11:3], want.center));
        if (out_tdata[27:12] !== want.obj_range)
          report_mismatch($sformatf("dist got %0d want %0d", out_tdata[27:12],
                                    want.obj_range));
        if (out_tdata[43:28] !== want.diam)
          report_mismatch($sformatf("diameter got %0d want %0d", out_tdata[43:28], want.diam));
      end
    end
  end

  task automatic segment_step(input bit st, input logic [ANGLE_W-1:0] ang,
                              input logic [IR_W-1:0] ir, input logic [DIST_W-1:0] son,
                              output bit emit, output obj_t obj);
    logic [63:0] prod;
    logic [63:0] val;
    logic [ANGLE_W-1:0] span;
    emit = 1'b0;
    obj = '0;
    if (st) begin
      seg_qual = '0;
      seg_open = 1'b0;
      seg_start_ang = '0;
      seg_end_ang = '0;
      seg_dist = '0;
      seg_count = '0;
    end
    if (ir > seg_thr) begin
      if (seg_qual < QUAL_SAMPLES) begin
        seg_qual = seg_qual + 1'b1;
      end else begin
        if (!seg_open) begin
          seg_open = 1'b1;
          seg_start_ang = ang;
          seg_dist = son;
        end
        seg_end_ang = ang;
      end
    end else begin
      seg_qual = '0;
      if (seg_open) begin
        seg_open = 1'b0;
        if (seg_count < MAX_OBJ) begin
          span = (seg_end_ang >= seg_start_ang) ? seg_end_ang - seg_start_ang : '0;
          prod = 64'(seg_dist) * 64'(span) * 64'(PI_OVER_180_Q16);
          val = (prod + 64'd32768) >> 16;
          emit = 1'b1;
          obj.index = seg_count[IDX_W-1:0];
          obj.center = CENTER_W'(seg_start_ang) + CENTER_W'(seg_end_ang);
          obj.obj_range = seg_dist;
          obj.diam = (val > 64'd65535) ? 16'hFFFF : val[15:0];
          seg_count = seg_count + 1'b1;
        end
      end
    end
  endtask

  // called at a rising edge; returns at the edge that accepts the transaction
  task automatic send_sample(input bit st, input int ang, input int ir, input int son,
                             input bit typed, input obj_t typed_obj);
    bit emit;
    obj_t obj;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= st;
    in_tdata  <= {4'b0, son[15:0], ir[11:0], ang[7:0]};
    do @(posedge clk); while (!in_tready);
    segment_step(st, ang[7:0], ir[11:0], son[15:0], emit, obj);
    if (typed) pending_objects.push_back(typed_obj);
    else if (emit) pending_objects.push_back(obj);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_objects.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input int value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value[IR_W-1:0];
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    seg_thr = value[IR_W-1:0];
  endtask

  function automatic int level_above();
    if (seg_thr == 12'hFFF) return 4095;
    return $urandom_range(4095, int'(seg_thr) + 1);
  endfunction

  function automatic int pick_dist();
    case ($urandom_range(9))
      0: return 65535;
      1: return $urandom_range(255);
      default: return $urandom_range(65535);
    endcase
  endfunction

  function automatic int next_angle(input bit wild);
    if (wild) return $urandom_range(255);
    sweep_angle = sweep_angle + $urandom_range(3);
    if (sweep_angle > 180) sweep_angle = 0;
    return sweep_angle;
  endfunction

  task automatic scan_burst(input int n_items);
    int sent;
    int r;
    int q;
    bit wild;
    sent = 0;
    sweep_angle = 0;
    send_sample(1'b1, 0, $urandom_range(4095), pick_dist(), 1'b0, '0);
    sent++;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 8) begin
        send_sample($urandom_range(7) == 0, $urandom_range(255), $urandom_range(4095),
                    $urandom_range(65535), 1'b0, '0);
        sent++;
      end else if (r < 12) begin
        sweep_angle = 0;
        send_sample(1'b1, next_angle(1'b0), level_above(), pick_dist(), 1'b0, '0);
        sent++;
      end else begin
        q = $urandom_range(10);
        wild = ($urandom_range(9) == 0);
        for (int k = 0; k < q; k++) begin
          send_sample(1'b0, next_angle(wild), level_above(), pick_dist(), 1'b0, '0);
          sent++;
        end
        send_sample(1'b0, next_angle(wild), $urandom_range(int'(seg_thr), 0), pick_dist(),
                    1'b0, '0);
        sent++;
        if ($urandom_range(99) < 3) wait_drained();
      end
    end
  endtask

  dir_row_t dir_rows[N_DIR];
  int       phase_thr[N_PHASES];
  int       phase_items[N_PHASES];

  initial begin
    obj_t lit;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    mismatch_count = 0;
    send_idle_pct = 6;
    recv_idle_pct = 49;
    seg_thr = '0;
    seg_qual = '0;
    seg_open = 1'b0;
    seg_start_ang = '0;
    seg_end_ang = '0;
    seg_dist = '0;
    seg_count = '0;

    // threshold 100 during this part
    dir_rows = '{
      // three ignored, open at 10, close at threshold level
      '{1,   0,  200,     0, 0, 0,   0,     0,     0},
      '{0,   5,  101,     7, 0, 0,   0,     0,     0},
      '{0,   8, 4095,     9, 0, 0,   0,     0,     0},
      '{0,  10, 4095,  1000, 0, 0,   0,     0,     0},
      '{0,  20,  150,     3, 0, 0,   0,     0,     0},
      '{0,  25,  100,     4, 1, 0,  30,  1000,   175},
      // full span at max distance saturates
      '{0,   0,  200,     0, 0, 0,   0,     0,     0},
      '{0,   0,  200,     0, 0, 0,   0,     0,     0},
      '{0,   0,  200,     0, 0, 0,   0,     0,     0},
      '{0,   0,  300, 65535, 0, 0,   0,     0,     0},
      '{0, 180,  300,     1, 0, 0,   0,     0,     0},
      '{0,  90,    0,     0, 1, 1, 180, 65535, 65535},
      // angle going backwards
      '{0, 255,  200,     0, 0, 0,   0,     0,     0},
      '{0, 255,  200,     0, 0, 0,   0,     0,     0},
      '{0, 255,  200,     0, 0, 0,   0,     0,     0},
      '{0, 255,  200,     5, 0, 0,   0,     0,     0},
      '{0,   0,  200, 65535, 0, 0,   0,     0,     0},
      '{0,   3,   50,     0, 1, 2, 255,     5,     0},
      // run broken during qualification
      '{0,  40,  200,     0, 0, 0,   0,     0,     0},
      '{0,  41,  200,     0, 0, 0,   0,     0,     0},
      '{0,  42,  100,     0, 0, 0,   0,     0,     0},
      // open run dropped by a new scan
      '{0,  44,  200,     0, 0, 0,   0,     0,     0},
      '{0,  46,  200,     0, 0, 0,   0,     0,     0},
      '{0,  48,  200,     0, 0, 0,   0,     0,     0},
      '{0,  50,  200,    77, 0, 0,   0,     0,     0},
      '{1,  60,   10,     0, 0, 0,   0,     0,     0}
    };
    phase_thr   = '{0, 4095, 2048, 0, 1, 4094};
    phase_items = '{200, 50, 200, 200, 200, 200};
    phase_thr[3] = $urandom_range(4095);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_threshold(100);
    for (int i = 0; i < N_DIR; i++) begin
      lit.index     = dir_rows[i].index[IDX_W-1:0];
      lit.center    = dir_rows[i].center[CENTER_W-1:0];
      lit.obj_range = dir_rows[i].obj_range[DIST_W-1:0];
      lit.diam      = dir_rows[i].diam[DIAM_W-1:0];
      send_sample(dir_rows[i].st, dir_rows[i].angle, dir_rows[i].ir, dir_rows[i].sonar,
                  dir_rows[i].typed, lit);
    end
    wait_drained();

    for (int p = 0; p < N_PHASES; p++) begin
      if (p < 2) begin
        send_idle_pct = 6;
        recv_idle_pct = 49;
      end else if (p < 4) begin
        send_idle_pct = 49;
        recv_idle_pct = 6;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_threshold(phase_thr[p]);
      while ((phase_items[p] > 0)) begin
        scan_burst($urandom_range(80, 20));
        phase_items[p] = phase_items[p] - 50;
      end
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
